FILE: hdl/pth_pkg.sv
// ----------------------------------------------------------------------------
// pth_pkg: shared types and codes for the pointer tracking hash table
// Action codes, slot states, status codes and the engine state type.
// ----------------------------------------------------------------------------
package pth_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_MARK   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SWEEP  = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_NOP    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    E_IDLE,
    E_CLR,
    E_PCHK,
    E_DONE,
    E_SCNT,
    E_SSCAN,
    E_SNULL
  } eng_state_t;

  // Handshake bundle between the queue and the engine.
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

FILE: hdl/pointer_tracking_hash_table.sv
// ----------------------------------------------------------------------------
// pointer_tracking_hash_table: tracked address table with mark and sweep
// Open addressed table of allocation addresses, linear probing, tombstones.
// ----------------------------------------------------------------------------
// Each input beat carries an action and a key. Slot state, mark and key live
// in one RAM entry per slot with a registered read. Insert, mark and remove
// take the beat from the queue while reading the home slot
// (key >> 3) mod TABLE_SLOTS, then visit the probe chain slot by slot and
// emit one result beat. Sweep makes two passes over the table (count, then
// free) and gives one result beat per freed key, or a single beat if none
// is freed, the final beat flagged by last; every beat of a sweep already
// reports the live count after the whole sweep. Clear runs a pass that
// empties every slot, then gives one beat; the same pass runs right after
// reset, so the first beat is taken from the queue only once that pass is
// done. Unknown actions give one beat. When TABLE_SLOTS is not a power of
// two the input stage reduces the key four bits per cycle before handing it
// off; a two entry queue lets that overlap with the engine. Results sit in
// an output register, so the engine keeps working until a beat is stalled.
// ----------------------------------------------------------------------------
module pointer_tracking_hash_table #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS    = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       action,
  input  logic [KEY_BITS-1:0]              key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [$clog2(TABLE_SLOTS)-1:0]   slot,
  output logic                             freed_valid,
  output logic [KEY_BITS-1:0]              freed_key,
  output logic                             last,
  output logic [$clog2(TABLE_SLOTS+1)-1:0] live_count,
  output logic                             load_high
);
  import pth_pkg::*;

  localparam int QW = 3 + KEY_BITS + $clog2(TABLE_SLOTS);

  logic          q_full, push, q_ne, q_pop;
  logic [QW-1:0] push_data, q_head;
  q_ctl_t        q_ctl;

  pth_front #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .key       (key),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pth_fifo #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .head      (q_head)
  );

  assign q_ctl.valid = q_ne;
  assign q_ctl.pop   = q_pop;

  pth_engine #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_in        (q_ctl),
    .q_pop       (q_pop),
    .q_data      (q_head),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .freed_valid (freed_valid),
    .freed_key   (freed_key),
    .last        (last),
    .live_count  (live_count),
    .load_high   (load_high)
  );

`ifndef ASSERT_OFF
  // live count can never pass the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (live_count <= ($clog2(TABLE_SLOTS+1))'(TABLE_SLOTS)))
    else $error("live_count above table size");

  // load flag agrees with the reported count
  a_load_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (load_high == ((32'(live_count) * 4) > (3 * TABLE_SLOTS))))
    else $error("load_high inconsistent with live_count");

  // a freed key beat is always a successful sweep beat
  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && freed_valid) |-> (status == STATUS_OK))
    else $error("freed beat with error status");

  // queue pop only when an entry is present
  a_pop_ne: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_ne)
    else $error("queue popped while empty");
`endif

endmodule

FILE: hdl/pth_ram.sv
// ----------------------------------------------------------------------------
// pth_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pth_front.sv
// ----------------------------------------------------------------------------
// pth_front: input stage
// Accepts beats, maps the action to an op code and computes the home slot.
// ----------------------------------------------------------------------------
module pth_front #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS    = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [KEY_BITS-1:0]            key,
  input  logic                           q_full,
  output logic                           push,
  output logic [3+KEY_BITS+$clog2(TABLE_SLOTS)-1:0] push_data
);
  import pth_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int DB = KEY_BITS - 3;
  localparam int ND = (DB + 3) / 4;
  localparam int PB = ND * 4;
  localparam int CB = $clog2(ND + 1);
  localparam int VW = SW + 4;
  localparam bit IS_POW2 = (TABLE_SLOTS == (1 << SW));
  localparam logic [VW-1:0] M1 = VW'(TABLE_SLOTS);
  localparam logic [VW-1:0] M2 = VW'(2 * TABLE_SLOTS);
  localparam logic [VW-1:0] M4 = VW'(4 * TABLE_SLOTS);
  localparam logic [VW-1:0] M8 = VW'(8 * TABLE_SLOTS);

  logic                busy;
  op_t                 op_h;
  logic [KEY_BITS-1:0] key_h;
  logic [SW-1:0]       rem;
  logic [PB-1:0]       dvd;
  logic [CB-1:0]       digits_left;
  logic [VW-1:0]       v0, v1, v2, v3, v4;
  op_t                 op_in;
  logic                acc;

  always_comb begin
    case (action)
      3'd0:    op_in = OP_INSERT;
      3'd1:    op_in = OP_MARK;
      3'd2:    op_in = OP_REMOVE;
      3'd3:    op_in = OP_SWEEP;
      3'd4:    op_in = OP_CLEAR;
      default: op_in = OP_NOP;
    endcase
  end

  assign in_stall = busy | q_full;
  assign acc      = in_valid & ~in_stall;

  // radix-16 reduction, four dividend bits per cycle, MSB first
  assign v0 = {rem, dvd[PB-1 -: 4]};
  assign v1 = (v0 >= M8) ? v0 - M8 : v0;
  assign v2 = (v1 >= M4) ? v1 - M4 : v1;
  assign v3 = (v2 >= M2) ? v2 - M2 : v2;
  assign v4 = (v3 >= M1) ? v3 - M1 : v3;

  always_comb begin
    push      = 1'b0;
    push_data = {op_h, key_h, rem};
    if (IS_POW2) begin
      push      = acc;
      push_data = {op_in, key, key[3 +: SW]};
    end else if (busy && digits_left == '0 && !q_full) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!IS_POW2) begin
      if (acc) begin
        busy        <= 1'b1;
        op_h        <= op_in;
        key_h       <= key;
        rem         <= '0;
        dvd         <= PB'(key[KEY_BITS-1:3]);
        digits_left <= CB'(ND);
      end else if (busy) begin
        if (digits_left != '0) begin
          rem         <= v4[SW-1:0];
          dvd         <= dvd << 4;
          digits_left <= digits_left - 1'b1;
        end else if (!q_full) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/pth_fifo.sv
// ----------------------------------------------------------------------------
// pth_fifo: two entry queue
// Decouples the input stage from the table engine.
// ----------------------------------------------------------------------------
module pth_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/pth_engine.sv
// ----------------------------------------------------------------------------
// pth_engine: table engine
// Probes, updates slot state and marks, runs sweeps and drives result beats.
// ----------------------------------------------------------------------------
module pth_engine #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS    = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pth_pkg::q_ctl_t                  q_in,
  output logic                             q_pop,
  input  logic [3+KEY_BITS+$clog2(TABLE_SLOTS)-1:0] q_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [$clog2(TABLE_SLOTS)-1:0]   slot,
  output logic                             freed_valid,
  output logic [KEY_BITS-1:0]              freed_key,
  output logic                             last,
  output logic [$clog2(TABLE_SLOTS+1)-1:0] live_count,
  output logic                             load_high
);
  import pth_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = 3 + KEY_BITS;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
  localparam logic [CW+1:0] LOAD_LIM  = (CW+2)'(3 * TABLE_SLOTS);

  eng_state_t          state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  op_t                 op, q_op;
  logic [KEY_BITS-1:0] key_r;
  logic [SW-1:0]       cur, steps, free_idx, fidx, q_home;
  logic                free_ok, found;
  logic [CW-1:0]       nfree, rem;
  logic                none_freed;
  logic [CW-1:0]       nfree_tot;

  logic                take, emit, adv, rd_en, we;
  logic [SW-1:0]       cur_inc, raddr, waddr;
  logic [EW-1:0]       rdata, wdata;
  slot_state_t         r_st;
  logic                r_mk;
  logic [KEY_BITS-1:0] r_key;
  logic                key_hit, sweep_hit;

  logic [1:0]          e_status;
  logic [SW-1:0]       e_slot;
  logic                e_fv, e_last;

  // slot entry: {state, mark, key}
  assign take      = ~out_valid | ~out_stall;
  assign cur_inc   = (cur == LAST_SLOT) ? '0 : cur + 1'b1;
  assign q_op      = op_t'(q_data[3+KEY_BITS+SW-1 -: 3]);
  assign q_home    = (q_op inside {OP_SWEEP, OP_CLEAR}) ? '0 : q_data[SW-1:0];
  assign r_st      = slot_state_t'(rdata[EW-1 -: 2]);
  assign r_mk      = rdata[KEY_BITS];
  assign r_key     = rdata[KEY_BITS-1:0];
  assign key_hit   = (r_st == SLOT_LIVE) & (r_key == key_r);
  assign sweep_hit = (r_st == SLOT_LIVE) & ~r_mk;
  assign nfree_tot = nfree + CW'(sweep_hit);
  assign q_pop     = (state == E_IDLE) & q_in.valid;

  pth_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    raddr      = cur_inc;
    adv        = 1'b0;
    we         = 1'b0;
    waddr      = cur;
    wdata      = {SLOT_EMPTY, 1'b0, {KEY_BITS{1'b0}}};
    emit       = 1'b0;
    e_status   = STATUS_OK;
    e_slot     = '0;
    e_fv       = 1'b0;
    e_last     = 1'b1;
    cnt_next   = cnt;
    case (state)
      E_IDLE: begin
        if (q_in.valid) begin
          rd_en = 1'b1;
          raddr = q_home;
          case (q_op)
            OP_INSERT, OP_MARK, OP_REMOVE: state_next = E_PCHK;
            OP_SWEEP:                      state_next = E_SCNT;
            OP_CLEAR:                      state_next = E_CLR;
            default:                       state_next = E_DONE;
          endcase
        end
      end
      E_CLR: begin
        we  = 1'b1;
        adv = 1'b1;
        if (cur == LAST_SLOT) begin
          state_next = (op == OP_CLEAR) ? E_DONE : E_IDLE;
        end
      end
      E_PCHK: begin
        if (key_hit || r_st == SLOT_EMPTY || steps == LAST_SLOT) begin
          state_next = E_DONE;
        end else begin
          rd_en = 1'b1;
          adv   = 1'b1;
        end
      end
      E_DONE: begin
        if (take) begin
          emit       = 1'b1;
          state_next = E_IDLE;
          case (op)
            OP_INSERT: begin
              if (found) begin
                e_slot = fidx;
                we     = 1'b1;
                waddr  = fidx;
                wdata  = {SLOT_LIVE, 1'b0, key_r};
              end else if (free_ok) begin
                e_slot   = free_idx;
                we       = 1'b1;
                waddr    = free_idx;
                wdata    = {SLOT_LIVE, 1'b0, key_r};
                cnt_next = cnt + 1'b1;
              end else begin
                e_status = STATUS_FULL;
              end
            end
            OP_MARK: begin
              if (found) begin
                e_slot = fidx;
                we     = 1'b1;
                waddr  = fidx;
                wdata  = {SLOT_LIVE, 1'b1, key_r};
              end else begin
                e_status = STATUS_NOT_FOUND;
              end
            end
            OP_REMOVE: begin
              if (found) begin
                e_slot   = fidx;
                we       = 1'b1;
                waddr    = fidx;
                wdata    = {SLOT_TOMB, 1'b0, key_r};
                cnt_next = cnt - 1'b1;
              end else begin
                e_status = STATUS_NOT_FOUND;
              end
            end
            OP_CLEAR: cnt_next = '0;
            default:  cnt_next = cnt;
          endcase
        end
      end
      E_SCNT: begin
        rd_en = 1'b1;
        adv   = 1'b1;
        if (cur == LAST_SLOT) begin
          cnt_next   = cnt - nfree_tot;
          state_next = E_SSCAN;
        end
      end
      E_SSCAN: begin
        if (sweep_hit) begin
          // unmarked entry: free it as soon as the output register is open
          if (take) begin
            emit   = 1'b1;
            e_slot = cur;
            e_fv   = 1'b1;
            e_last = (rem == CW'(1));
            we     = 1'b1;
            wdata  = {SLOT_TOMB, 1'b0, r_key};
            adv    = 1'b1;
            rd_en  = (cur != LAST_SLOT);
            if (cur == LAST_SLOT) state_next = E_IDLE;
          end
        end else begin
          if (r_st == SLOT_LIVE) begin
            we    = 1'b1;
            wdata = {SLOT_LIVE, 1'b0, r_key};
          end
          adv   = 1'b1;
          rd_en = (cur != LAST_SLOT);
          if (cur == LAST_SLOT) state_next = none_freed ? E_SNULL : E_IDLE;
        end
      end
      E_SNULL: begin
        if (take) begin
          emit       = 1'b1;
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      op  <= OP_NOP;
    end else begin
      if (q_pop) begin
        op      <= q_op;
        key_r   <= q_data[SW +: KEY_BITS];
        cur     <= q_home;
        steps   <= '0;
        free_ok <= 1'b0;
        found   <= 1'b0;
        nfree   <= '0;
      end else if (adv) begin
        cur <= cur_inc;
      end
      case (state)
        E_PCHK: begin
          if (key_hit) begin
            found <= 1'b1;
            fidx  <= cur;
          end else if (r_st != SLOT_LIVE && op == OP_INSERT && !free_ok) begin
            free_idx <= cur;
            free_ok  <= 1'b1;
          end
          if (adv) steps <= steps + 1'b1;
        end
        E_SCNT: begin
          nfree <= nfree_tot;
          if (cur == LAST_SLOT) begin
            rem        <= nfree_tot;
            none_freed <= (nfree_tot == '0);
          end
        end
        E_SSCAN: begin
          if (sweep_hit && take) rem <= rem - 1'b1;
        end
        default: ;
      endcase
    end
    if (emit) begin
      status      <= e_status;
      slot        <= e_slot;
      freed_valid <= e_fv;
      freed_key   <= e_fv ? r_key : '0;
      last        <= e_last;
      live_count  <= cnt_next;
      load_high   <= ({cnt_next, 2'b00} > LOAD_LIM);
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: pointer tracking hash table check
// Drives insert, mark, remove, sweep and clear beats, predicts every result
// beat with a behavioral table and compares each field in order.
// ----------------------------------------------------------------------------
module testbench;
  import pth_pkg::*;

  localparam int SLOTS = 64;
  localparam int KB    = 48;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic [2:0]    act;
    logic [KB-1:0] k;
  } beat_in_t;

  typedef struct {
    logic [1:0]    st;
    logic [5:0]    sl;
    logic          fv;
    logic [KB-1:0] fk;
    logic          lst;
    logic [6:0]    cnt;
    logic          lh;
  } beat_out_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [KB-1:0] key = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [5:0] slot;
  logic freed_valid;
  logic [KB-1:0] freed_key;
  logic last;
  logic [6:0] live_count;
  logic load_high;

  pointer_tracking_hash_table #(.TABLE_SLOTS(SLOTS), .KEY_BITS(KB)) u_top (.*);

  always #10 clk = ~clk;

  // Shadow table state
  logic [KB-1:0] tbl_key[SLOTS];
  slot_state_t   tbl_state[SLOTS];
  logic          tbl_mark[SLOTS];
  int            tbl_live;

  beat_in_t  pending_q[$];
  beat_out_t expected_q[$];
  logic [KB-1:0] key_pool[$];

  int errors = 0;
  int cycles = 0;
  int n_sent = 0, n_recv = 0, n_freed = 0, n_full = 0;
  bit quiet = 0;         // no idling in the final stretch
  bit hold_long = 0;     // long receiver hold-off requested
  int send_gap = 0, recv_gap = 0;

  function automatic void push_result(logic [1:0] st, int sl, logic fv, logic [KB-1:0] fk);
    beat_out_t r;
    r.st = st; r.sl = sl[5:0]; r.fv = fv; r.fk = fk;
    r.lst = 0; r.cnt = 0; r.lh = 0;
    expected_q.push_back(r);
  endfunction

  // Apply one accepted beat to the shadow table and queue its results.
  function automatic void predict_table(beat_in_t b);
    int base, h, idx, found, free_i;
    base = expected_q.size();
    h = int'((b.k >> 3) % SLOTS);
    found = -1; free_i = -1;
    case (b.act)
      OP_INSERT: begin
        for (int j = 0; j < SLOTS; j++) begin
          idx = (h + j) % SLOTS;
          if (tbl_state[idx] == SLOT_LIVE) begin
            if (tbl_key[idx] == b.k) begin found = idx; break; end
          end else begin
            if (free_i < 0) free_i = idx;
            if (tbl_state[idx] == SLOT_EMPTY) break;
          end
        end
        if (found >= 0) begin
          tbl_mark[found] = 0;
          push_result(STATUS_OK, found, 0, '0);
        end else if (free_i >= 0) begin
          tbl_key[free_i] = b.k; tbl_state[free_i] = SLOT_LIVE;
          tbl_mark[free_i] = 0; tbl_live++;
          push_result(STATUS_OK, free_i, 0, '0);
        end else begin
          n_full++;
          push_result(STATUS_FULL, 0, 0, '0);
        end
      end
      OP_MARK, OP_REMOVE: begin
        for (int j = 0; j < SLOTS; j++) begin
          idx = (h + j) % SLOTS;
          if (tbl_state[idx] == SLOT_EMPTY) break;
          if (tbl_state[idx] == SLOT_LIVE && tbl_key[idx] == b.k) begin
            found = idx; break;
          end
        end
        if (found < 0) push_result(STATUS_NOT_FOUND, 0, 0, '0);
        else begin
          if (b.act == OP_MARK) tbl_mark[found] = 1;
          else begin
            tbl_state[found] = SLOT_TOMB; tbl_mark[found] = 0;
            if (tbl_live > 0) tbl_live--;
          end
          push_result(STATUS_OK, found, 0, '0);
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_state[i] != SLOT_LIVE) continue;
          if (tbl_mark[i]) tbl_mark[i] = 0;
          else begin
            tbl_state[i] = SLOT_TOMB;
            if (tbl_live > 0) tbl_live--;
            n_freed++;
            push_result(STATUS_OK, i, 1, tbl_key[i]);
          end
        end
        if (expected_q.size() == base) push_result(STATUS_OK, 0, 0, '0);
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_state[i] = SLOT_EMPTY; tbl_mark[i] = 0;
        end
        tbl_live = 0;
        push_result(STATUS_OK, 0, 0, '0);
      end
      default: push_result(STATUS_OK, 0, 0, '0);
    endcase
    // count and load are after the whole step; last on the final beat
    for (int i = base; i < expected_q.size(); i++) begin
      expected_q[i].lst = (i == expected_q.size() - 1);
      expected_q[i].cnt = tbl_live[6:0];
      expected_q[i].lh  = (tbl_live * 4 > SLOTS * 3);
    end
  endfunction

  // Random key: mostly from the pool of recent keys, sometimes fresh.
  // Fresh keys favor a few home slots so probe chains and wraps happen.
  function automatic logic [KB-1:0] pick_key();
    logic [KB-1:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 99) < 55)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) k[8:3] = 6'($urandom_range(60, 63));
    if ($urandom_range(0, 9) == 0) k = 48'($urandom_range(0, 1));
    key_pool.push_back(k);
    if (key_pool.size() > 40) void'(key_pool.pop_front());
    return k;
  endfunction

  function automatic void add_beat(logic [2:0] a, logic [KB-1:0] k);
    beat_in_t b;
    b.act = a; b.k = k;
    pending_q.push_back(b);
  endfunction

  // Driver: valid held while stalled, payload stable.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_table('{act: action, k: key});
        n_sent <= n_sent + 1;
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 0;
      end else if (pending_q.size() > 0 &&
                   (quiet || $urandom_range(0, 9) != 0)) begin
        beat_in_t b;
        b = pending_q.pop_front();
        in_valid <= 1; action <= b.act; key <= b.k;
      end else begin
        in_valid <= 0;
        if (!quiet && pending_q.size() > 0) send_gap <= $urandom_range(0, 7);
      end
    end
  end

  // Monitor and receiver stall control.
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        beat_out_t e;
        n_recv <= n_recv + 1;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat slot=%0d", slot);
        end else begin
          e = expected_q.pop_front();
          if (status !== e.st || slot !== e.sl || freed_valid !== e.fv ||
              freed_key !== e.fk || last !== e.lst || live_count !== e.cnt ||
              load_high !== e.lh) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp st=%0d sl=%0d fv=%0d fk=%h l=%0d c=%0d lh=%0d got st=%0d sl=%0d fv=%0d fk=%h l=%0d c=%0d lh=%0d",
                e.st, e.sl, e.fv, e.fk, e.lst, e.cnt, e.lh,
                status, slot, freed_valid, freed_key, last, live_count, load_high);
          end
        end
      end
      if (hold_long) begin
        // long hold-off so the input side backs up
        out_stall <= 1;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt >= 400) begin hold_long <= 0; hold_cnt <= 0; end
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] a;
    int r;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_state[i] = SLOT_EMPTY; tbl_mark[i] = 0; tbl_key[i] = '0;
    end
    tbl_live = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: reserved keys, extremes, present and absent keys, all actions.
    add_beat(OP_SWEEP, '0);                 // sweep on empty table
    add_beat(OP_INSERT, 48'd0);
    add_beat(OP_INSERT, 48'd1);             // same home slot as 0
    add_beat(OP_INSERT, {KB{1'b1}});        // home slot is the last slot, 63
    add_beat(OP_INSERT, 48'h5555_5555_5555);
    add_beat(OP_INSERT, 48'hAAAA_AAAA_AAAA);
    add_beat(OP_INSERT, 48'd1);             // already present
    add_beat(OP_MARK, 48'd1);
    add_beat(OP_MARK, 48'h1234);            // absent
    add_beat(OP_REMOVE, 48'd0);             // leaves tombstone
    add_beat(OP_REMOVE, 48'd0);             // absent now
    add_beat(OP_MARK, 48'd1);               // past the tombstone
    add_beat(OP_INSERT, 48'd1);             // present beyond tombstone, clears mark
    add_beat(OP_MARK, {KB{1'b1}});
    add_beat(OP_SWEEP, '0);
    add_beat(3'd5, 48'd7);
    add_beat(3'd7, 48'd7);
    add_beat(OP_CLEAR, '0);
    drain();

    // Fill past three quarters, then to full, to see load_high and full status.
    for (int i = 0; i < 66; i++) add_beat(OP_INSERT, 48'(i * 8 + 2));
    add_beat(OP_INSERT, 48'd40000);         // found after full? no: full
    hold_long = 1;                          // receiver holds off while sender keeps going
    add_beat(OP_SWEEP, '0);                 // frees all 64
    drain();                                // sender pauses until all results arrive

    // Random: mostly sequences of insert, mark, occasional sweep.
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) a = OP_INSERT;
      else if (r < 70) a = OP_MARK;
      else if (r < 88) a = OP_REMOVE;
      else if (r < 95) a = OP_SWEEP;
      else if (r < 98) a = OP_CLEAR;
      else a = 3'($urandom_range(5, 7));
      add_beat(a, pick_key());
      if (i == 150) begin
        hold_long = 1;
        drain();
      end
    end
    drain();
    quiet = 1;
    for (int i = 0; i < 40; i++)
      add_beat($urandom_range(0, 3) == 0 ? OP_MARK : OP_INSERT, pick_key());
    add_beat(OP_SWEEP, '0);
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d input beats, %0d result beats, %0d freed keys, %0d full inserts",
             n_sent, n_recv, n_freed, n_full);
    if (errors == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
